@@ hw/rtl/indexed_pairing_heap_top_assert.svh @@
// ---------------------------------------------------------------------------
// indexed pairing heap assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef INDEXED_PAIRING_HEAP_TOP_ASSERT_SVH
`define INDEXED_PAIRING_HEAP_TOP_ASSERT_SVH

// a implies b at the same edge
`define IPH_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("iph check failed");

// a stalled transaction keeps its valid and data
`define IPH_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
        else $error("iph stalled transaction changed");

`endif

@@ hw/rtl/iph_pkg.sv @@
// ---------------------------------------------------------------------------
// iph_pkg
// types and codes shared by the indexed pairing heap modules
// ---------------------------------------------------------------------------
package iph_pkg;

    localparam int CAP      = 1024;
    localparam int ID_W     = 10;
    localparam int LNK_W    = ID_W + 1;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 88;

    localparam logic [LNK_W-1:0] NIL = {LNK_W{1'b1}};

    // entry status
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_POPPED = 2'd2;

    // command codes on the input
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // classified kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // push outcomes
    localparam logic [1:0] OUT_INSERTED = 2'd0;
    localparam logic [1:0] OUT_LOWERED  = 2'd1;
    localparam logic [1:0] OUT_REJECTED = 2'd2;
    localparam logic [1:0] OUT_NO_PUSH  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [LNK_W-1:0]  fc;
        logic [LNK_W-1:0]  par;
        logic [LNK_W-1:0]  lft;
        logic [LNK_W-1:0]  rgt;
    } t_node;

endpackage

@@ hw/rtl/iph_front.sv @@
// ---------------------------------------------------------------------------
// iph_front
// accepts input transactions, classifies the command and queues them
// ---------------------------------------------------------------------------
module iph_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [iph_pkg::IN_W-1:0] i_s_tdata,
    input  iph_pkg::t_back_stat     i_stat,
    output logic                    o_q_valid,
    output iph_pkg::t_item          o_q_item,
    input  logic                    i_q_pop
);

    iph_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    iph_pkg::t_item w_item;
    logic           w_push;

    always_comb begin
        w_item.id   = i_s_tdata[11:2];
        w_item.key  = i_s_tdata[43:12];
        w_item.data = i_s_tdata[75:44];
        unique case (i_s_tdata[1:0])
            iph_pkg::CMD_PUSH:  w_item.kind = iph_pkg::KIND_PUSH;
            iph_pkg::CMD_POP:   w_item.kind = iph_pkg::KIND_POP;
            iph_pkg::CMD_CLEAR: w_item.kind = iph_pkg::KIND_CLEAR;
            default:            w_item.kind = iph_pkg::KIND_NOP;
        endcase
    end

    assign o_s_tready = (r_cnt != 2'd2) && !i_stat.sweeping;
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

@@ hw/rtl/iph_back.sv @@
// ---------------------------------------------------------------------------
// iph_back
// executes heap commands on the node memory and holds the result register
// ---------------------------------------------------------------------------
module iph_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  iph_pkg::t_item            i_q_item,
    output logic                      o_q_pop,
    output iph_pkg::t_back_stat       o_stat,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [iph_pkg::OUT_W-1:0] o_m_tdata
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLR      = 5'd1;
    localparam logic [4:0] S_PUSH_CHK = 5'd2;
    localparam logic [4:0] S_LOW_PAR  = 5'd3;
    localparam logic [4:0] S_LOW_RS   = 5'd4;
    localparam logic [4:0] S_LOW_LS   = 5'd5;
    localparam logic [4:0] S_LOW_PW   = 5'd6;
    localparam logic [4:0] S_LOW_IW   = 5'd7;
    localparam logic [4:0] S_SETROOT  = 5'd8;
    localparam logic [4:0] S_POP_OLD  = 5'd9;
    localparam logic [4:0] S_WALK     = 5'd10;
    localparam logic [4:0] S_PAIR     = 5'd11;
    localparam logic [4:0] S_PAIR_A   = 5'd12;
    localparam logic [4:0] S_PAIR_B   = 5'd13;
    localparam logic [4:0] S_PAIR_W   = 5'd14;
    localparam logic [4:0] S_MRG0     = 5'd15;
    localparam logic [4:0] S_MRG      = 5'd16;
    localparam logic [4:0] S_MRG_B    = 5'd17;
    localparam logic [4:0] S_MRG_W    = 5'd18;
    localparam logic [4:0] S_MA       = 5'd19;
    localparam logic [4:0] S_MB       = 5'd20;
    localparam logic [4:0] S_MC       = 5'd21;
    localparam logic [4:0] S_MD       = 5'd22;
    localparam logic [4:0] S_ME       = 5'd23;
    localparam logic [4:0] S_MF       = 5'd24;
    localparam logic [4:0] S_FIN      = 5'd25;
    localparam logic [4:0] S_OUT      = 5'd26;

    localparam int IW = iph_pkg::ID_W;
    localparam int LW = iph_pkg::LNK_W;

    // node and scratch memories
    iph_pkg::t_node r_mem [iph_pkg::CAP];
    logic [IW-1:0]  r_cl  [iph_pkg::CAP];
    iph_pkg::t_node r_rd;
    logic [IW-1:0]  r_cl_rd;

    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    iph_pkg::t_node mem_wdata;
    logic [IW-1:0]  mem_raddr;
    logic           cl_we;
    logic [IW-1:0]  cl_waddr;
    logic [IW-1:0]  cl_wdata;
    logic [IW-1:0]  cl_raddr;

    logic [4:0]                 r_state, n_state;
    logic [4:0]                 r_ret, n_ret;
    logic [LW-1:0]              r_a, n_a, r_b, n_b;
    logic [LW-1:0]              r_root, n_root, r_mres, n_mres;
    logic [LW-1:0]              r_win, n_win, r_lose, n_lose, r_c, n_c;
    iph_pkg::t_node             r_ra, n_ra, r_wrec, n_wrec, r_lrec, n_lrec;
    iph_pkg::t_node             r_na, n_na, r_nb, n_nb;
    logic [IW-1:0]              r_id, n_id;
    logic [iph_pkg::KEY_W-1:0]  r_key, n_key;
    logic [iph_pkg::DATA_W-1:0] r_data, n_data;
    logic [LW-1:0]              r_rs, n_rs, r_ls, n_ls, r_sib, n_sib;
    logic [LW-1:0]              r_n, n_n, r_i, n_i;
    logic [IW-1:0]              r_cnt, n_cnt;
    logic                       r_sweep_rst, n_sweep_rst;
    logic [1:0]                 r_outcome, n_outcome;
    logic                       r_pv, n_pv;
    logic [IW-1:0]              r_pid, n_pid;
    logic                       r_o_valid, n_o_valid;
    logic [iph_pkg::OUT_W-1:0]  r_o_data, n_o_data;

    logic [LW-1:0]  w_pairs;
    logic [LW-1:0]  w_two_i;
    logic           w_a_wins;
    iph_pkg::t_node w_rec;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            r_cl[cl_waddr] <= cl_wdata;
        end
        r_cl_rd <= r_cl[cl_raddr];
    end

    assign w_pairs  = (r_n + LW'(1)) >> 1;
    assign w_two_i  = r_i << 1;
    assign w_a_wins = r_ra.key < r_rd.key;

    assign o_stat.sweeping = (r_state == S_CLR) && r_sweep_rst;
    assign o_m_tvalid      = r_o_valid;
    assign o_m_tdata       = r_o_data;

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_a = r_a;       n_b = r_b;
        n_root = r_root;     n_mres = r_mres;   n_win = r_win;   n_lose = r_lose;
        n_c = r_c;           n_ra = r_ra;       n_wrec = r_wrec; n_lrec = r_lrec;
        n_na = r_na;         n_nb = r_nb;       n_id = r_id;     n_key = r_key;
        n_data = r_data;     n_rs = r_rs;       n_ls = r_ls;     n_sib = r_sib;
        n_n = r_n;           n_i = r_i;         n_cnt = r_cnt;   n_sweep_rst = r_sweep_rst;
        n_outcome = r_outcome; n_pv = r_pv;     n_pid = r_pid;
        n_o_valid = r_o_valid && !i_m_tready;
        n_o_data = r_o_data;
        mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;
        mem_raddr = r_root[IW-1:0];
        cl_we = 1'b0;   cl_waddr = '0;   cl_wdata = '0;   cl_raddr = '0;
        o_q_pop = 1'b0;
        w_rec = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_id      = i_q_item.id;
                    n_key     = i_q_item.key;
                    n_data    = i_q_item.data;
                    n_outcome = iph_pkg::OUT_NO_PUSH;
                    n_pv      = 1'b0;
                    n_pid     = '0;
                    unique case (i_q_item.kind)
                        iph_pkg::KIND_PUSH: begin
                            mem_raddr = i_q_item.id;
                            n_state   = S_PUSH_CHK;
                        end
                        iph_pkg::KIND_POP: begin
                            n_state = r_root[LW-1] ? S_FIN : S_POP_OLD;
                        end
                        iph_pkg::KIND_CLEAR: begin
                            n_cnt       = '0;
                            n_sweep_rst = 1'b0;
                            n_state     = S_CLR;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                n_root    = iph_pkg::NIL;
                n_cnt     = r_cnt + IW'(1);
                if (r_cnt == IW'(iph_pkg::CAP - 1)) begin
                    n_state = r_sweep_rst ? S_IDLE : S_FIN;
                end
            end
            S_PUSH_CHK: begin
                if (r_rd.status == iph_pkg::ST_POPPED) begin
                    n_outcome = iph_pkg::OUT_REJECTED;
                    n_state   = S_FIN;
                end else if (r_rd.status == iph_pkg::ST_FREE) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_id;
                    mem_wdata = '{status: iph_pkg::ST_QUEUED, key: r_key, data: r_data,
                                  fc: iph_pkg::NIL, par: iph_pkg::NIL,
                                  lft: iph_pkg::NIL, rgt: iph_pkg::NIL};
                    n_outcome = iph_pkg::OUT_INSERTED;
                    n_a       = r_root;
                    n_b       = {1'b0, r_id};
                    n_ret     = S_SETROOT;
                    n_state   = S_MA;
                end else if (r_rd.key < r_key) begin
                    n_outcome = iph_pkg::OUT_REJECTED;
                    n_state   = S_FIN;
                end else begin
                    w_rec.key  = r_key;
                    w_rec.data = r_data;
                    mem_we     = 1'b1;
                    mem_waddr  = r_id;
                    mem_wdata  = w_rec;
                    n_na       = w_rec;
                    n_rs       = r_rd.rgt;
                    n_ls       = r_rd.lft;
                    n_outcome  = iph_pkg::OUT_LOWERED;
                    if (({1'b0, r_id} == r_root) || r_rd.par[LW-1]) begin
                        n_state = S_FIN;
                    end else begin
                        mem_raddr = r_rd.par[IW-1:0];
                        n_state   = S_LOW_PAR;
                    end
                end
            end
            S_LOW_PAR: begin
                n_nb = r_rd;
                if (r_key > r_rd.key) begin
                    n_state = S_FIN;
                end else if (!r_rs[LW-1]) begin
                    mem_raddr = r_rs[IW-1:0];
                    n_state   = S_LOW_RS;
                end else if (!r_ls[LW-1]) begin
                    mem_raddr = r_ls[IW-1:0];
                    n_state   = S_LOW_LS;
                end else begin
                    n_state = S_LOW_PW;
                end
            end
            S_LOW_RS: begin
                w_rec.lft = r_ls;
                mem_we    = 1'b1;
                mem_waddr = r_rs[IW-1:0];
                mem_wdata = w_rec;
                if (!r_ls[LW-1]) begin
                    mem_raddr = r_ls[IW-1:0];
                    n_state   = S_LOW_LS;
                end else begin
                    n_state = S_LOW_PW;
                end
            end
            S_LOW_LS: begin
                w_rec.rgt = r_rs;
                mem_we    = 1'b1;
                mem_waddr = r_ls[IW-1:0];
                mem_wdata = w_rec;
                n_state   = S_LOW_PW;
            end
            S_LOW_PW: begin
                // parent record only changes when this node heads its child list
                if (r_nb.fc == {1'b0, r_id}) begin
                    w_rec     = r_nb;
                    w_rec.fc  = r_rs;
                    mem_we    = 1'b1;
                    mem_waddr = r_na.par[IW-1:0];
                    mem_wdata = w_rec;
                end
                n_state = S_LOW_IW;
            end
            S_LOW_IW: begin
                w_rec     = r_na;
                w_rec.par = iph_pkg::NIL;
                w_rec.lft = iph_pkg::NIL;
                w_rec.rgt = iph_pkg::NIL;
                mem_we    = 1'b1;
                mem_waddr = r_id;
                mem_wdata = w_rec;
                n_a       = r_root;
                n_b       = {1'b0, r_id};
                n_ret     = S_SETROOT;
                n_state   = S_MA;
            end
            S_SETROOT: begin
                n_root  = r_mres;
                n_state = S_FIN;
            end
            S_POP_OLD: begin
                w_rec.status = iph_pkg::ST_POPPED;
                w_rec.fc     = iph_pkg::NIL;
                w_rec.par    = iph_pkg::NIL;
                w_rec.lft    = iph_pkg::NIL;
                w_rec.rgt    = iph_pkg::NIL;
                mem_we       = 1'b1;
                mem_waddr    = r_root[IW-1:0];
                mem_wdata    = w_rec;
                n_pv         = 1'b1;
                n_pid        = r_root[IW-1:0];
                n_root       = iph_pkg::NIL;
                n_n          = '0;
                n_sib        = r_rd.fc;
                if (!r_rd.fc[LW-1]) begin
                    mem_raddr = r_rd.fc[IW-1:0];
                    n_state   = S_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK: begin
                // collect the child list and detach each child on the way
                cl_we     = 1'b1;
                cl_waddr  = r_n[IW-1:0];
                cl_wdata  = r_sib[IW-1:0];
                w_rec.par = iph_pkg::NIL;
                w_rec.lft = iph_pkg::NIL;
                w_rec.rgt = iph_pkg::NIL;
                mem_we    = 1'b1;
                mem_waddr = r_sib[IW-1:0];
                mem_wdata = w_rec;
                n_n       = r_n + LW'(1);
                n_sib     = r_rd.rgt;
                if (!r_rd.rgt[LW-1]) begin
                    mem_raddr = r_rd.rgt[IW-1:0];
                end else begin
                    n_i     = '0;
                    n_state = S_PAIR;
                end
            end
            S_PAIR: begin
                if (r_i == w_pairs) begin
                    n_i      = w_pairs - LW'(1);
                    cl_raddr = IW'(w_pairs - LW'(1));
                    n_state  = S_MRG0;
                end else begin
                    cl_raddr = w_two_i[IW-1:0];
                    n_state  = S_PAIR_A;
                end
            end
            S_PAIR_A: begin
                n_a = {1'b0, r_cl_rd};
                if ((w_two_i + LW'(1)) < r_n) begin
                    cl_raddr = IW'(w_two_i + LW'(1));
                    n_state  = S_PAIR_B;
                end else begin
                    n_b     = iph_pkg::NIL;
                    n_ret   = S_PAIR_W;
                    n_state = S_MA;
                end
            end
            S_PAIR_B: begin
                n_b     = {1'b0, r_cl_rd};
                n_ret   = S_PAIR_W;
                n_state = S_MA;
            end
            S_PAIR_W: begin
                // pair results overwrite list slots that are already consumed
                cl_we    = 1'b1;
                cl_waddr = r_i[IW-1:0];
                cl_wdata = r_mres[IW-1:0];
                n_i      = r_i + LW'(1);
                n_state  = S_PAIR;
            end
            S_MRG0: begin
                n_root  = {1'b0, r_cl_rd};
                n_state = S_MRG;
            end
            S_MRG: begin
                if (r_i == '0) begin
                    n_state = S_FIN;
                end else begin
                    cl_raddr = IW'(r_i - LW'(1));
                    n_state  = S_MRG_B;
                end
            end
            S_MRG_B: begin
                n_a     = r_root;
                n_b     = {1'b0, r_cl_rd};
                n_ret   = S_MRG_W;
                n_state = S_MA;
            end
            S_MRG_W: begin
                n_root  = r_mres;
                n_i     = r_i - LW'(1);
                n_state = S_MRG;
            end
            S_MA: begin
                if (r_a[LW-1]) begin
                    n_mres  = r_b;
                    n_state = r_ret;
                end else if (r_b[LW-1]) begin
                    n_mres  = r_a;
                    n_state = r_ret;
                end else begin
                    mem_raddr = r_a[IW-1:0];
                    n_state   = S_MB;
                end
            end
            S_MB: begin
                n_ra      = r_rd;
                mem_raddr = r_b[IW-1:0];
                n_state   = S_MC;
            end
            S_MC: begin
                // first argument wins only on a strictly smaller key
                n_win  = w_a_wins ? r_a : r_b;
                n_lose = w_a_wins ? r_b : r_a;
                n_wrec = w_a_wins ? r_ra : r_rd;
                n_lrec = w_a_wins ? r_rd : r_ra;
                n_c    = w_a_wins ? r_ra.fc : r_rd.fc;
                if (!n_c[LW-1]) begin
                    mem_raddr = n_c[IW-1:0];
                    n_state   = S_MD;
                end else begin
                    n_state = S_ME;
                end
            end
            S_MD: begin
                w_rec.lft = r_lose;
                mem_we    = 1'b1;
                mem_waddr = r_c[IW-1:0];
                mem_wdata = w_rec;
                n_state   = S_ME;
            end
            S_ME: begin
                w_rec     = r_lrec;
                w_rec.rgt = r_c;
                w_rec.par = r_win;
                mem_we    = 1'b1;
                mem_waddr = r_lose[IW-1:0];
                mem_wdata = w_rec;
                n_state   = S_MF;
            end
            S_MF: begin
                w_rec     = r_wrec;
                w_rec.fc  = r_lose;
                mem_we    = 1'b1;
                mem_waddr = r_win[IW-1:0];
                mem_wdata = w_rec;
                n_mres    = r_win;
                n_state   = r_ret;
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    if (r_root[LW-1]) begin
                        n_o_data = {64'd0, 11'd0, r_pid, r_pv, r_outcome};
                    end else begin
                        n_o_data = {r_rd.data, r_rd.key, r_root[IW-1:0], 1'b1,
                                    r_pid, r_pv, r_outcome};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_sweep_rst <= 1'b1;
            r_root      <= iph_pkg::NIL;
            r_o_valid   <= 1'b0;
            r_ret       <= S_IDLE;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sweep_rst <= n_sweep_rst;
            r_root      <= n_root;
            r_o_valid   <= n_o_valid;
            r_ret       <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;       r_b <= n_b;         r_mres <= n_mres;
        r_win <= n_win;   r_lose <= n_lose;   r_c <= n_c;
        r_ra <= n_ra;     r_wrec <= n_wrec;   r_lrec <= n_lrec;
        r_na <= n_na;     r_nb <= n_nb;       r_id <= n_id;
        r_key <= n_key;   r_data <= n_data;   r_rs <= n_rs;
        r_ls <= n_ls;     r_sib <= n_sib;     r_n <= n_n;
        r_i <= n_i;       r_outcome <= n_outcome;
        r_pv <= n_pv;     r_pid <= n_pid;     r_o_data <= n_o_data;
    end

endmodule

@@ hw/rtl/indexed_pairing_heap_top.sv @@
// ---------------------------------------------------------------------------
// indexed_pairing_heap_top
// id-indexed min pairing heap with decrease-key, one result per command
// ---------------------------------------------------------------------------
// Commands run one at a time on a simple dual-port node memory (one read and
// one write per cycle, registered read), so the run time of a command follows
// the number of memory accesses. A push reads the entry and then runs a meld; a
// key lowering that cuts its node also unlinks it first. A pop walks each child
// of the old root and then melds in the two pairing passes, logarithmic when
// amortized. A clear sweeps all 1024 entries. After reset the same sweep runs
// with the input not ready. Two commands can wait in the input queue while the
// back end is busy, and the result register lets the next command start while
// a result is still held.
// ---------------------------------------------------------------------------
module indexed_pairing_heap_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // command[1:0], item_id[11:2], priority_req[43:12], payload[75:44], zero fill
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // push_outcome[1:0], popped_valid[2], popped_id[12:3], min_valid[13],
    // min_id[23:14], min_priority[55:24], min_payload[87:56]
    output logic [87:0] o_m_tdata
);

    logic                q_valid;
    iph_pkg::t_item      q_item;
    logic                q_pop;
    iph_pkg::t_back_stat stat;

    iph_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_stat     (stat),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    iph_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ hw/rtl/iph_checker.sv @@
// ---------------------------------------------------------------------------
// iph_checker
// port-level checks on the result stream of the heap
// ---------------------------------------------------------------------------
`include "indexed_pairing_heap_top_assert.svh"

module iph_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [87:0] o_m_tdata
);

    `IPH_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_m_tvalid, i_m_tready, o_m_tdata)
    `IPH_ASSERT_IMPLY(a_pid_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[2], o_m_tdata[12:3] == 10'd0)
    `IPH_ASSERT_IMPLY(a_pop_no_push, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[2], o_m_tdata[1:0] == iph_pkg::OUT_NO_PUSH)
    `IPH_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[13], o_m_tdata[87:14] == 74'd0)

endmodule

bind indexed_pairing_heap_top iph_checker u_iph_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/tb_indexed_pairing_heap_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_indexed_pairing_heap_top
// drives push, pop and clear commands into the pairing heap, predicts every
// result with a behavioral pairing heap and compares each result field
// ---------------------------------------------------------------------------
module tb_indexed_pairing_heap_top;

    localparam int NULL_IX = 32'hFFFF_FFFF;
    localparam int LIMIT_CYCLES = 2_000_000;

    // lowest field last, matching the result tdata layout
    typedef struct packed {
        logic [31:0] min_data;
        logic [31:0] min_key;
        logic [9:0]  min_id;
        logic        min_vld;
        logic [9:0]  pop_id;
        logic        pop_vld;
        logic [1:0]  outcome;
    } t_heap_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;

    indexed_pairing_heap_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // command, item_id, priority_req, payload
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // outcome, popped v/id, min v/id/key/payload
    );

    // heap shadow
    logic [1:0]  hp_stat [iph_pkg::CAP];
    logic [31:0] hp_key  [iph_pkg::CAP];
    logic [31:0] hp_data [iph_pkg::CAP];
    int          hp_fc   [iph_pkg::CAP];
    int          hp_par  [iph_pkg::CAP];
    int          hp_lft  [iph_pkg::CAP];
    int          hp_rgt  [iph_pkg::CAP];
    int          hp_root;
    int          kids    [iph_pkg::CAP];
    int          pairs_r [iph_pkg::CAP];

    t_heap_res   heap_results_due[$];
    int          err_cnt, cyc_cnt, sent_cnt, got_cnt, pop_cnt, lower_cnt;
    bit          quiet_mode;

    initial i_clk = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cyc_cnt);
            $display("tb_indexed_pairing_heap_top NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, got_cnt);
    endtask

    function automatic void unlink_heap();
        for (int i = 0; i < iph_pkg::CAP; i++) begin
            hp_fc[i] = NULL_IX; hp_par[i] = NULL_IX;
            hp_lft[i] = NULL_IX; hp_rgt[i] = NULL_IX;
        end
        hp_root = NULL_IX;
    endfunction

    function automatic int meld_roots(int a, int b);
        int win, lose, c;
        if (a == NULL_IX) return b;
        if (b == NULL_IX) return a;
        // equal keys go to the second root
        if (hp_key[a] < hp_key[b]) begin win = a; lose = b; end
        else begin win = b; lose = a; end
        c = hp_fc[win];
        if (c != NULL_IX) begin
            hp_lft[c] = lose;
            hp_rgt[lose] = c;
        end
        hp_fc[win] = lose;
        hp_par[lose] = win;
        return win;
    endfunction

    function automatic int pop_root();
        int old, sib, n, np;
        n = 0;
        if (hp_root == NULL_IX) return NULL_IX;
        old = hp_root;
        hp_stat[old] = iph_pkg::ST_POPPED;
        sib = hp_fc[old];
        hp_fc[old] = NULL_IX; hp_rgt[old] = NULL_IX;
        hp_lft[old] = NULL_IX; hp_par[old] = NULL_IX;
        hp_root = NULL_IX;
        while (sib != NULL_IX) begin
            kids[n++] = sib;
            sib = hp_rgt[sib];
        end
        if (n == 0) return old;
        for (int i = 0; i < n; i++) begin
            hp_rgt[kids[i]] = NULL_IX; hp_lft[kids[i]] = NULL_IX;
            hp_par[kids[i]] = NULL_IX;
        end
        np = (n + 1) / 2;
        for (int i = 0; i < np; i++)
            pairs_r[i] = meld_roots(kids[2*i], (2*i+1 < n) ? kids[2*i+1] : NULL_IX);
        hp_root = pairs_r[np-1];
        for (int i = np - 1; i > 0; i--)
            hp_root = meld_roots(hp_root, pairs_r[i-1]);
        return old;
    endfunction

    function automatic t_heap_res predict_heap_step(logic [1:0] cmd, logic [9:0] id,
                                                    logic [31:0] key, logic [31:0] data);
        t_heap_res r;
        int p, rs, ls, old, ix;
        r = '0;
        ix = int'(id);
        r.outcome = iph_pkg::OUT_NO_PUSH;
        if (cmd == iph_pkg::CMD_PUSH) begin
            if (hp_stat[ix] == iph_pkg::ST_POPPED) r.outcome = iph_pkg::OUT_REJECTED;
            else if (hp_stat[ix] == iph_pkg::ST_FREE) begin
                hp_key[ix] = key; hp_data[ix] = data; hp_stat[ix] = iph_pkg::ST_QUEUED;
                hp_root = meld_roots(hp_root, ix);
                r.outcome = iph_pkg::OUT_INSERTED;
            end else if (hp_key[ix] < key) r.outcome = iph_pkg::OUT_REJECTED;
            else begin
                r.outcome = iph_pkg::OUT_LOWERED;
                hp_key[ix] = key; hp_data[ix] = data;
                p = hp_par[ix];
                if (ix != hp_root && p != NULL_IX && key <= hp_key[p]) begin
                    rs = hp_rgt[ix]; ls = hp_lft[ix];
                    if (rs != NULL_IX) hp_lft[rs] = ls;
                    if (ls != NULL_IX) hp_rgt[ls] = rs;
                    if (hp_fc[p] == ix) hp_fc[p] = rs;
                    hp_rgt[ix] = NULL_IX; hp_lft[ix] = NULL_IX; hp_par[ix] = NULL_IX;
                    hp_root = meld_roots(hp_root, ix);
                end
            end
        end else if (cmd == iph_pkg::CMD_POP) begin
            old = pop_root();
            if (old != NULL_IX) begin
                r.pop_vld = 1'b1;
                r.pop_id = old[9:0];
            end
        end else if (cmd == iph_pkg::CMD_CLEAR) begin
            for (int i = 0; i < iph_pkg::CAP; i++) hp_stat[i] = iph_pkg::ST_FREE;
            unlink_heap();
        end
        if (hp_root != NULL_IX) begin
            r.min_vld = 1'b1;
            r.min_id = hp_root[9:0];
            r.min_key = hp_key[hp_root];
            r.min_data = hp_data[hp_root];
        end
        return r;
    endfunction

    // sends one command; may idle before it unless quiet_mode
    task automatic send_cmd(input logic [1:0] cmd, input logic [9:0] id,
                            input logic [31:0] key, input logic [31:0] data);
        while (!quiet_mode && $urandom_range(99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  <= {4'b0, data, key, id, cmd};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        heap_results_due.push_back(predict_heap_step(cmd, id, key, data));
        sent_cnt++;
        if (cmd == iph_pkg::CMD_POP) pop_cnt++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        i_m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 22);

    always @(posedge i_clk) begin
        t_heap_res g, w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            g = o_m_tdata;
            got_cnt++;
            if (heap_results_due.size() == 0)
                report_mismatch("unexpected result", o_m_tdata[31:0], 32'd0);
            else begin
                w = heap_results_due.pop_front();
                if (g.outcome != w.outcome)
                    report_mismatch("push_outcome", 32'(g.outcome), 32'(w.outcome));
                if (g.pop_vld != w.pop_vld)
                    report_mismatch("popped_valid", 32'(g.pop_vld), 32'(w.pop_vld));
                if (g.pop_id != w.pop_id)
                    report_mismatch("popped_id", 32'(g.pop_id), 32'(w.pop_id));
                if (g.min_vld != w.min_vld)
                    report_mismatch("min_valid", 32'(g.min_vld), 32'(w.min_vld));
                if (g.min_id != w.min_id)
                    report_mismatch("min_id", 32'(g.min_id), 32'(w.min_id));
                if (g.min_key != w.min_key) report_mismatch("min_priority", g.min_key, w.min_key);
                if (g.min_data != w.min_data)
                    report_mismatch("min_payload", g.min_data, w.min_data);
                if (w.outcome == iph_pkg::OUT_LOWERED) lower_cnt++;
            end
        end
    end

    task automatic test_directed();
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);                 // pop on empty heap
        send_cmd(iph_pkg::CMD_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // ignored
        send_cmd(iph_pkg::CMD_PUSH, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(iph_pkg::CMD_PUSH, 10'h3FF, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_PUSH, 10'h155, 32'h100, 32'hAAAA_5555);
        send_cmd(iph_pkg::CMD_PUSH, 10'h2AA, 32'h100, 32'h5555_AAAA);    // equal keys
        send_cmd(iph_pkg::CMD_PUSH, 10'h155, 32'h200, 32'h1);            // higher key rejected
        send_cmd(iph_pkg::CMD_PUSH, 10'h155, 32'h100, 32'h2);            // equal key lowers
        send_cmd(iph_pkg::CMD_PUSH, 10'd0, 32'h50, 32'h3);               // lowered, no cut: parent key still smaller
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_PUSH, 10'h3FF, 32'h0, 32'h4);              // popped id rejected
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_CLEAR, 10'd0, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_PUSH, 10'h3FF, 32'h7, 32'h8);              // free again
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);
        send_cmd(iph_pkg::CMD_POP, 10'd0, 32'h0, 32'h0);
    endtask

    // rounds of inserts, key lowerings and pops over an id window of 4 to 64 ids or all 1024
    task automatic test_random();
        int n, span, base, r;
        logic [31:0] key;
        n = 0;
        while (n < 1100) begin
            span = $urandom_range(3) == 0 ? 1024 : $urandom_range(64, 4);
            base = $urandom_range(1024 - span);
            quiet_mode = (n > 500 && n < 650);
            for (int k = 0; k < 60 && n < 1100; k++, n++) begin
                r = $urandom_range(99);
                key = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
                if (r < 55)
                    send_cmd(iph_pkg::CMD_PUSH, 10'(base + $urandom_range(span - 1)), key,
                             $urandom);
                else if (r < 92)
                    send_cmd(iph_pkg::CMD_POP, 10'($urandom), $urandom, $urandom);
                else if (r < 96)
                    send_cmd(iph_pkg::CMD_NONE, 10'($urandom), $urandom, $urandom);
                else if (r < 98)
                    send_cmd(iph_pkg::CMD_CLEAR, 10'($urandom), $urandom, $urandom);
                else
                    send_cmd(iph_pkg::CMD_PUSH, 10'(base), 32'hFFFF_FFFF, $urandom);
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        int wait_cyc;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_m_tready = 1'b0;
        cyc_cnt = 0; err_cnt = 0; sent_cnt = 0; got_cnt = 0;
        pop_cnt = 0; lower_cnt = 0; quiet_mode = 1'b0;
        for (int i = 0; i < iph_pkg::CAP; i++) hp_stat[i] = iph_pkg::ST_FREE;
        unlink_heap();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        i_s_tvalid <= 1'b0;
        wait_cyc = 0;
        while (heap_results_due.size() != 0 && wait_cyc < 200000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (2000) @(posedge i_clk);
        if (heap_results_due.size() != 0) begin
            err_cnt++;
            $display("%0d results never arrived", heap_results_due.size());
        end
        $display("sent %0d commands (%0d pops), checked %0d results, %0d key lowerings",
                 sent_cnt, pop_cnt, got_cnt, lower_cnt);
        if (err_cnt == 0)
            $display("tb_indexed_pairing_heap_top OK");
        else
            $display("tb_indexed_pairing_heap_top NOT OK");
        $finish;
    end

endmodule
